### design/text_console_writer_macros.svh
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;

  localparam int NUM_W  = 64;
  localparam int DIGITS = 20;
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = $clog2(NUM_W + 1);
  localparam int PTR_W  = $clog2(DIGITS);
  localparam int IDX_W  = 11;
  localparam int POS_W  = 16;

  localparam logic [9:0] PORT_INDEX      = 10'h3D4;
  localparam logic [9:0] PORT_DATA       = 10'h3D5;
  localparam logic [7:0] CURSOR_HIGH_REG = 8'h0E;
  localparam logic [7:0] CURSOR_LOW_REG  = 8'h0F;
  localparam logic [7:0] NEWLINE         = 8'h0A;
  localparam logic [7:0] ASCII_ZERO      = 8'h30;
  localparam logic [7:0] TEXT_COLOR_RST  = 8'h07;

  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_PLOT   = 2'd2;
  localparam logic [1:0] KIND_CURSOR = 2'd3;

  localparam logic OUT_CELL = 1'b0;
  localparam logic OUT_PORT = 1'b1;

  localparam logic [1:0] STEP_LOW_INDEX  = 2'd0;
  localparam logic [1:0] STEP_LOW_DATA   = 2'd1;
  localparam logic [1:0] STEP_HIGH_INDEX = 2'd2;
  localparam logic [1:0] STEP_HIGH_DATA  = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHAR  = 6'b000010,
    ST_PLOT  = 6'b000100,
    ST_CONV  = 6'b001000,
    ST_DIGIT = 6'b010000,
    ST_PORT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic start;
    logic shift;
  } bcd_ctrl_t;

endpackage

### design/tcw_bcd.sv
`timescale 1ns / 1ps

module tcw_bcd import tcw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  bcd_ctrl_t        ctrl,
  input  logic [NUM_W-1:0] value,
  output logic             busy,
  output logic [3:0]       top_digit
);

  logic [NUM_W-1:0] bin;
  logic [BCD_W-1:0] digits;
  logic [BCD_W-1:0] adj;
  logic [CNT_W-1:0] count;

  // add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[4*i +: 4] = (digits[4*i +: 4] >= 4'd5) ? digits[4*i +: 4] + 4'd3
                                                 : digits[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (ctrl.start) begin
      busy  <= 1'b1;
      count <= CNT_W'(NUM_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin    <= value;
      digits <= '0;
    end else if (busy) begin
      digits <= {adj[BCD_W-2:0], bin[NUM_W-1]};
      bin    <= {bin[NUM_W-2:0], 1'b0};
    end else if (ctrl.shift) begin
      digits <= {digits[BCD_W-5:0], 4'd0};
    end
  end

  assign top_digit = digits[BCD_W-1 -: 4];

endmodule

### design/text_console_writer.sv
`timescale 1ns / 1ps

// chan | valid     | stall     | fields
// cfg  | cfg_write | none      | cfg_data (text_color)
// in   | in_valid  | in_stall  | kind char_code last_of_string number_value pos_x pos_y plot_color
// out  | out_valid | out_stall | out_kind cell_index cell_value port_address port_data last
//
// one request at a time; a request with no result leaves in_stall low
// a number goes through the shift-add-3 unit, then a skip-or-digit step for each of the 20 digits and
// 4 port writes; in_stall stays high from the accept until the last port write is taken
// characters give 0 to 5 results, plots 0 or 1, cursor sets 4
// each result waits in the output register until out_stall is low
// rst is synchronous: cursor at 0,0, text color 7, output empty, input stalled

module text_console_writer import tcw_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       kind,
  input  logic [7:0]       char_code,
  input  logic             last_of_string,
  input  logic [NUM_W-1:0] number_value,
  input  logic [6:0]       pos_x,
  input  logic [4:0]       pos_y,
  input  logic [7:0]       plot_color,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [IDX_W-1:0] cell_index,
  output logic [15:0]      cell_value,
  output logic [9:0]       port_address,
  output logic [7:0]       port_data,
  output logic             last
);

  localparam int COL_W = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int ROW_W = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

  state_t           state, state_next;
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;
  logic [7:0]       text_color;
  logic [1:0]       step, step_next;
  logic             port_pend, port_pend_next;
  logic [PTR_W-1:0] ptr, ptr_next;
  logic             started, started_next;
  logic [7:0]       held_char;
  logic [7:0]       held_attr;
  logic [IDX_W-1:0] plot_index;

  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;
  logic             col_wrap;
  logic [ROW_W-1:0] row_adv;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] plot_pos;
  logic             px_on, py_on;
  logic             accept;
  logic             load;
  logic             bcd_busy;
  logic [3:0]       top_digit;
  bcd_ctrl_t        bcd_ctrl;

  logic             emit;
  logic             e_kind;
  logic [IDX_W-1:0] e_index;
  logic [15:0]      e_value;
  logic [9:0]       e_addr;
  logic [7:0]       e_data;
  logic             e_last;

  tcw_bcd u_bcd (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (bcd_ctrl),
    .value     (number_value),
    .busy      (bcd_busy),
    .top_digit (top_digit)
  );

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load     = !out_valid || !out_stall;

  assign col_inc  = (COL_W+1)'(col) + (COL_W+1)'(1);
  assign row_inc  = (ROW_W+1)'(row) + (ROW_W+1)'(1);
  assign col_wrap = (col_inc >= (COL_W+1)'(SCREEN_WIDTH));
  assign row_adv  = (row_inc >= (ROW_W+1)'(SCREEN_HEIGHT)) ? '0 : row_inc[ROW_W-1:0];

  assign pos      = POS_W'(row) * POS_W'(SCREEN_WIDTH) + POS_W'(col);
  assign plot_pos = POS_W'(pos_y) * POS_W'(SCREEN_WIDTH) + POS_W'(pos_x);
  assign px_on    = ({1'b0, pos_x} < 8'(SCREEN_WIDTH));
  assign py_on    = ({1'b0, pos_y} < 6'(SCREEN_HEIGHT));

  always_comb begin
    state_next     = state;
    col_next       = col;
    row_next       = row;
    step_next      = step;
    port_pend_next = port_pend;
    ptr_next       = ptr;
    started_next   = started;
    bcd_ctrl       = '0;
    emit           = 1'b0;
    e_kind         = OUT_CELL;
    e_index        = '0;
    e_value        = '0;
    e_addr         = '0;
    e_data         = '0;
    e_last         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          step_next = STEP_LOW_INDEX;
          case (kind)
            KIND_CHAR: begin
              if (char_code == NEWLINE) begin
                col_next   = '0;
                row_next   = row_adv;
                state_next = last_of_string ? ST_PORT : ST_IDLE;
              end else begin
                port_pend_next = last_of_string;
                state_next     = ST_CHAR;
              end
            end
            KIND_NUMBER: begin
              bcd_ctrl.start = 1'b1;
              state_next     = ST_CONV;
            end
            KIND_PLOT: begin
              state_next = (px_on && py_on) ? ST_PLOT : ST_IDLE;
            end
            KIND_CURSOR: begin
              col_next   = px_on ? COL_W'(pos_x) : COL_W'(SCREEN_WIDTH - 1);
              row_next   = py_on ? ROW_W'(pos_y) : ROW_W'(SCREEN_HEIGHT - 1);
              state_next = ST_PORT;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_CHAR: begin
        if (load) begin
          emit     = 1'b1;
          e_index  = pos[IDX_W-1:0];
          e_value  = {text_color, held_char};
          e_last   = !port_pend;
          col_next = col_wrap ? '0 : col_inc[COL_W-1:0];
          if (col_wrap) begin
            row_next = row_adv;
          end
          state_next = port_pend ? ST_PORT : ST_IDLE;
        end
      end
      ST_PLOT: begin
        if (load) begin
          emit       = 1'b1;
          e_index    = plot_index;
          e_value    = {held_attr, held_char};
          e_last     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CONV: begin
        if (!bcd_busy) begin
          ptr_next     = PTR_W'(DIGITS - 1);
          started_next = 1'b0;
          state_next   = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        // leading zeros are dropped, the units digit always prints
        if (!started && top_digit == 4'd0 && ptr != '0) begin
          bcd_ctrl.shift = 1'b1;
          ptr_next       = ptr - PTR_W'(1);
        end else if (load) begin
          emit           = 1'b1;
          e_index        = pos[IDX_W-1:0];
          e_value        = {text_color, ASCII_ZERO + {4'd0, top_digit}};
          bcd_ctrl.shift = 1'b1;
          started_next   = 1'b1;
          col_next       = col_wrap ? '0 : col_inc[COL_W-1:0];
          if (col_wrap) begin
            row_next = row_adv;
          end
          if (ptr == '0) begin
            state_next = ST_PORT;
          end else begin
            ptr_next = ptr - PTR_W'(1);
          end
        end
      end
      ST_PORT: begin
        if (load) begin
          emit      = 1'b1;
          e_kind    = OUT_PORT;
          step_next = step + 2'd1;
          case (step)
            STEP_LOW_INDEX: begin
              e_addr = PORT_INDEX;
              e_data = CURSOR_LOW_REG;
            end
            STEP_LOW_DATA: begin
              e_addr = PORT_DATA;
              e_data = pos[7:0];
            end
            STEP_HIGH_INDEX: begin
              e_addr = PORT_INDEX;
              e_data = CURSOR_HIGH_REG;
            end
            STEP_HIGH_DATA: begin
              e_addr     = PORT_DATA;
              e_data     = pos[15:8];
              e_last     = 1'b1;
              state_next = ST_IDLE;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      col        <= '0;
      row        <= '0;
      text_color <= TEXT_COLOR_RST;
      step       <= STEP_LOW_INDEX;
      port_pend  <= 1'b0;
      ptr        <= '0;
      started    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      col       <= col_next;
      row       <= row_next;
      step      <= step_next;
      port_pend <= port_pend_next;
      ptr       <= ptr_next;
      started   <= started_next;
      if (cfg_write) begin
        text_color <= cfg_data;
      end
      if (load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_char  <= char_code;
      held_attr  <= plot_color;
      plot_index <= plot_pos[IDX_W-1:0];
    end
    if (load) begin
      out_kind     <= e_kind;
      cell_index   <= e_index;
      cell_value   <= e_value;
      port_address <= e_addr;
      port_data    <= e_data;
      last         <= e_last;
    end
  end

endmodule

### design/tcw_checker.sv
`timescale 1ns / 1ps
`include "text_console_writer_macros.svh"

module tcw_checker import tcw_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [1:0]       kind,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_kind,
  input logic [IDX_W-1:0] cell_index,
  input logic [15:0]      cell_value,
  input logic [9:0]       port_address,
  input logic [7:0]       port_data,
  input logic             last
);

  `TCW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(cell_index) && $stable(cell_value) && $stable(port_data) && $stable(last), "stalled result changed")

  `TCW_ASSERT_NEXT(a_cursor_busy, in_valid && !in_stall && kind == KIND_CURSOR, in_stall, "cursor request did not hold off input")

  `TCW_ASSERT_NOW(a_cell_clean, out_valid && out_kind == OUT_CELL, port_address == 10'd0 && port_data == 8'd0, "cell write carries port fields")

  `TCW_ASSERT_NOW(a_port_index, out_valid && out_kind == OUT_PORT && port_address == PORT_INDEX, (port_data == CURSOR_LOW_REG || port_data == CURSOR_HIGH_REG) && !last && cell_index == '0 && cell_value == 16'd0, "bad cursor index write")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

### sim/tb_text_console_writer.sv
`timescale 1ns / 1ps

module tb_text_console_writer import tcw_pkg::*;;

  localparam int SCR_W     = SCREEN_WIDTH_DEF;
  localparam int SCR_H     = SCREEN_HEIGHT_DEF;
  localparam int IDLE_WAIT = 120;
  localparam int DRAIN_CAP = 20000;
  localparam int HOLD_LONG = 400;
  localparam int LIMIT_NS  = 8000000;

  typedef struct {
    logic [1:0]       kind;
    logic [7:0]       ch;
    logic             last_mark;
    logic [NUM_W-1:0] num;
    logic [6:0]       px;
    logic [4:0]       py;
    logic [7:0]       pc;
  } console_req_t;

  typedef struct {
    logic             okind;
    logic [IDX_W-1:0] idx;
    logic [15:0]      val;
    logic [9:0]       addr;
    logic [7:0]       data;
    logic             lst;
  } console_wr_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [7:0]       cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       kind = '0;
  logic [7:0]       char_code = '0;
  logic             last_of_string = 1'b0;
  logic [NUM_W-1:0] number_value = '0;
  logic [6:0]       pos_x = '0;
  logic [4:0]       pos_y = '0;
  logic [7:0]       plot_color = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_kind;
  logic [IDX_W-1:0] cell_index;
  logic [15:0]      cell_value;
  logic [9:0]       port_address;
  logic [7:0]       port_data;
  logic             last;

  // predicted console state
  int          cur_row = 0;
  int          cur_col = 0;
  logic [7:0]  text_color = TEXT_COLOR_RST;
  console_wr_t step_writes [24];
  int          nw;
  console_wr_t pending_writes [$];

  int mismatches = 0;
  int effective_items = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  text_console_writer dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .char_code      (char_code),
    .last_of_string (last_of_string),
    .number_value   (number_value),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .plot_color     (plot_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .cell_index     (cell_index),
    .cell_value     (cell_value),
    .port_address   (port_address),
    .port_data      (port_data),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("mismatch: %s expected %0h got %0h at %0t", what, exp_v, got_v, $time);
    mismatches++;
  endtask

  function automatic void add_write(input logic okind, input logic [IDX_W-1:0] idx,
                                    input logic [15:0] val, input logic [9:0] addr,
                                    input logic [7:0] data);
    step_writes[nw] = '{okind, idx, val, addr, data, 1'b0};
    nw++;
  endfunction

  function automatic void advance_row();
    cur_row++;
    if (cur_row >= SCR_H) cur_row = 0;
  endfunction

  function automatic void add_cell_write(input logic [7:0] c);
    add_write(OUT_CELL, IDX_W'(cur_row * SCR_W + cur_col), {text_color, c}, '0, '0);
    cur_col++;
    if (cur_col >= SCR_W) begin
      cur_col = 0;
      advance_row();
    end
  endfunction

  function automatic void add_cursor_writes();
    logic [15:0] pos;
    pos = 16'(cur_row * SCR_W + cur_col);
    add_write(OUT_PORT, '0, '0, PORT_INDEX, CURSOR_LOW_REG);
    add_write(OUT_PORT, '0, '0, PORT_DATA, pos[7:0]);
    add_write(OUT_PORT, '0, '0, PORT_INDEX, CURSOR_HIGH_REG);
    add_write(OUT_PORT, '0, '0, PORT_DATA, pos[15:8]);
  endfunction

  function automatic int predict_console_writes(input console_req_t r);
    logic [NUM_W-1:0] v;
    logic [3:0]       digs [20];
    int               nd;
    console_wr_t      w;
    nw = 0;
    case (r.kind)
      KIND_CHAR: begin
        if (r.ch == NEWLINE) begin
          cur_col = 0;
          advance_row();
        end else begin
          add_cell_write(r.ch);
        end
        if (r.last_mark) add_cursor_writes();
      end
      KIND_NUMBER: begin
        v = r.num;
        nd = 0;
        do begin
          digs[nd] = 4'(v % 10);
          v = v / 10;
          nd++;
        end while (v != 0 && nd < 20);
        for (int i = nd - 1; i >= 0; i--) add_cell_write(ASCII_ZERO + {4'b0000, digs[i]});
        add_cursor_writes();
      end
      KIND_PLOT: begin
        if (int'(r.px) < SCR_W && int'(r.py) < SCR_H)
          add_write(OUT_CELL, IDX_W'(int'(r.py) * SCR_W + int'(r.px)), {r.pc, r.ch}, '0, '0);
      end
      KIND_CURSOR: begin
        cur_col = (int'(r.px) < SCR_W) ? int'(r.px) : SCR_W - 1;
        cur_row = (int'(r.py) < SCR_H) ? int'(r.py) : SCR_H - 1;
        add_cursor_writes();
      end
      default: begin
      end
    endcase
    for (int i = 0; i < nw; i++) begin
      w = step_writes[i];
      w.lst = (i == nw - 1);
      pending_writes.push_back(w);
    end
    return nw;
  endfunction

  // receiver stall, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_writes
    console_wr_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("write with none pending", '0,
                        32'({out_kind, cell_index, port_address, port_data}));
      end else begin
        e = pending_writes.pop_front();
        if (out_kind !== e.okind) report_mismatch("out_kind", 32'(e.okind), 32'(out_kind));
        if (cell_index !== e.idx) report_mismatch("cell_index", 32'(e.idx), 32'(cell_index));
        if (cell_value !== e.val) report_mismatch("cell_value", 32'(e.val), 32'(cell_value));
        if (port_address !== e.addr)
          report_mismatch("port_address", 32'(e.addr), 32'(port_address));
        if (port_data !== e.data) report_mismatch("port_data", 32'(e.data), 32'(port_data));
        if (last !== e.lst) report_mismatch("last", 32'(e.lst), 32'(last));
      end
    end
  end

  task automatic send_item(input console_req_t r);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid       <= 1'b1;
    kind           <= r.kind;
    char_code      <= r.ch;
    last_of_string <= r.last_mark;
    number_value   <= r.num;
    pos_x          <= r.px;
    pos_y          <= r.py;
    plot_color     <= r.pc;
    do @(posedge clk); while (in_stall);
    if (predict_console_writes(r) > 0) effective_items++;
  endtask

  task automatic wait_drained(input int extra);
    @(negedge clk) in_valid <= 1'b0;
    for (int c = 0; c < DRAIN_CAP && pending_writes.size() != 0; c++) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_text_color(input logic [7:0] v);
    wait_drained(IDLE_WAIT);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    text_color = v;
    @(negedge clk) cfg_write <= 1'b0;
  endtask

  function automatic console_req_t make_req(input logic [1:0] k, input logic [7:0] c,
                                            input logic m, input logic [NUM_W-1:0] n,
                                            input logic [6:0] x, input logic [4:0] y,
                                            input logic [7:0] p);
    console_req_t r;
    r = '{k, c, m, n, x, y, p};
    return r;
  endfunction

  function automatic console_req_t noise_req();
    console_req_t r;
    r.kind      = 2'($urandom_range(3));
    r.ch        = 8'($urandom);
    r.last_mark = 1'($urandom);
    case ($urandom_range(3))
      0: r.num = NUM_W'($urandom_range(99));
      1: r.num = NUM_W'($urandom);
      2: r.num = {$urandom, $urandom};
      default: r.num = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    r.px = 7'($urandom);
    r.py = 5'($urandom);
    r.pc = 8'($urandom);
    return r;
  endfunction

  task automatic random_phase(input int count, input int s_idle, input int r_stall);
    console_req_t r;
    int goal;
    int len;
    int pick;
    send_idle_pct = s_idle;
    stall_pct = r_stall;
    goal = effective_items + count;
    while (effective_items < goal) begin
      pick = $urandom_range(99);
      r = noise_req();
      if (pick < 45) begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++) begin
          r = noise_req();
          r.kind = KIND_CHAR;
          if ($urandom_range(7) == 0) r.ch = NEWLINE;
          else if ($urandom_range(1) == 0) r.ch = 8'($urandom_range(126, 32));
          r.last_mark = (i == len - 1) && ($urandom_range(9) != 0);
          send_item(r);
        end
      end else if (pick < 62) begin
        r.kind = KIND_NUMBER;
        send_item(r);
      end else if (pick < 77) begin
        r.kind = KIND_PLOT;
        r.px = 7'($urandom_range(SCR_W - 1));
        r.py = 5'($urandom_range(SCR_H - 1));
        send_item(r);
      end else if (pick < 87) begin
        r.kind = KIND_CURSOR;
        if ($urandom_range(3) != 0) begin
          r.px = 7'($urandom_range(SCR_W - 1));
          r.py = 5'($urandom_range(SCR_H - 1));
        end
        send_item(r);
      end else begin
        send_item(r);
      end
    end
  endtask

  task automatic test_characters();
    send_item(make_req(KIND_CHAR, 8'h41, 1'b0, '0, '0, '0, '0));
    send_item(make_req(KIND_CHAR, 8'hFF, 1'b1, '1, '1, '1, '1));
    send_item(make_req(KIND_CHAR, 8'h00, 1'b0, '0, '0, '0, '0));
    send_item(make_req(KIND_CHAR, NEWLINE, 1'b0, '0, '0, '0, '0));
    send_item(make_req(KIND_CHAR, NEWLINE, 1'b1, '0, '0, '0, '0));
    set_text_color(8'hFF);
    send_item(make_req(KIND_CHAR, 8'h7E, 1'b1, '0, '0, '0, '0));
  endtask

  task automatic test_numbers();
    send_item(make_req(KIND_NUMBER, '0, 1'b0, '0, '0, '0, '0));
    send_item(make_req(KIND_NUMBER, '0, 1'b0, '1, '0, '0, '0));
    send_item(make_req(KIND_NUMBER, '0, 1'b0, 64'd1234567890, '0, '0, '0));
  endtask

  task automatic test_plots();
    send_item(make_req(KIND_PLOT, 8'h00, 1'b0, '0, 7'd0, 5'd0, 8'h00));
    send_item(make_req(KIND_PLOT, 8'hFF, 1'b0, '0, 7'd79, 5'd24, 8'hFF));
    // off screen, ignored
    send_item(make_req(KIND_PLOT, 8'h55, 1'b0, '0, 7'd80, 5'd0, 8'h12));
    send_item(make_req(KIND_PLOT, 8'h55, 1'b0, '0, 7'd127, 5'd31, 8'h12));
    send_item(make_req(KIND_PLOT, 8'h55, 1'b0, '0, 7'd0, 5'd25, 8'h12));
  endtask

  task automatic test_cursor_set();
    // column and row wrap together
    send_item(make_req(KIND_CURSOR, '0, 1'b0, '0, 7'd79, 5'd24, '0));
    send_item(make_req(KIND_CHAR, 8'h5A, 1'b1, '0, '0, '0, '0));
    // saturation off screen
    send_item(make_req(KIND_CURSOR, '0, 1'b0, '0, 7'd127, 5'd31, '0));
    send_item(make_req(KIND_CURSOR, '0, 1'b0, '0, 7'd79, 5'd0, '0));
    send_item(make_req(KIND_CHAR, 8'h61, 1'b0, '0, '0, '0, '0));
    send_item(make_req(KIND_CURSOR, '0, 1'b0, '0, 7'd0, 5'd24, '0));
    send_item(make_req(KIND_CHAR, NEWLINE, 1'b1, '0, '0, '0, '0));
    send_item(make_req(KIND_CURSOR, '0, 1'b0, '0, 7'd75, 5'd24, '0));
    send_item(make_req(KIND_NUMBER, '0, 1'b0, '1, '0, '0, '0));
    send_item(make_req(KIND_CURSOR, '0, 1'b0, '0, 7'd0, 5'd0, '0));
  endtask

  task automatic test_traffic();
    set_text_color(8'h00);
    random_phase(72, 0, 0);
    set_text_color(8'($urandom));
    random_phase(72, 78, 0);
    set_text_color(8'($urandom));
    random_phase(72, 0, 78);
    set_text_color(8'($urandom));
    random_phase(72, 38, 38);
  endtask

  task automatic test_backpressure();
    set_text_color(8'h1E);
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(make_req(KIND_NUMBER, '0, 1'b0, '1, '0, '0, '0));
    hold_req = HOLD_LONG;
    random_phase(20, 0, 0);
    // sender waits for every pending write
    wait_drained(0);
    random_phase(10, 38, 38);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_characters();
    test_numbers();
    test_plots();
    test_cursor_set();
    test_traffic();
    test_backpressure();
    wait_drained(IDLE_WAIT);
    if (pending_writes.size() != 0)
      report_mismatch("writes still pending", '0, 32'(pending_writes.size()));
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
